// File: rtl/vmt_pkg.sv
package vmt_pkg;

    localparam int unsigned CoordWidthDefault = 32;
    localparam int unsigned FracBits = 16;
    localparam int unsigned NumRegs = 8;
    localparam int unsigned RegIdxWidth = 3;
    localparam int unsigned SumWidth = 50;
    localparam int unsigned MagWidth = 49;
    localparam int unsigned IntWidth = 33;

    localparam logic [63:0] RegReset [NumRegs] = '{
        64'h0000_0000_8000_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0, 64'h0000_0000_0001_0000,
        64'h0, 64'h0001_0000_0000_0000
    };

    typedef struct packed {
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } t_in_item;

    typedef struct packed {
        logic        range_fault;
        logic signed [31:0] proj_z;
        logic signed [31:0] proj_y;
        logic signed [31:0] proj_x;
    } t_out_item;

    typedef struct packed {
        logic       valid;
        logic       w_zero;
        logic [2:0] neg;
    } t_div_ctl;

endpackage

// File: rtl/vmt_mac.sv
// Matrix multiply stages. Stage 1 forms the twelve floored products and
// registers matrix row 3 as is, stage 2 adds them into four exact sums and takes magnitudes.
module vmt_mac #(
    parameter int unsigned COORD_WIDTH = vmt_pkg::CoordWidthDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  vmt_pkg::t_in_item             i_item,
    input  logic [63:0]                   i_regs [vmt_pkg::NumRegs],
    output logic                          o_valid,
    output logic [vmt_pkg::MagWidth-1:0]  o_mag [4],
    output logic [3:0]                    o_neg
);

    logic signed [31:0] v [3];
    logic signed [31:0] m [4][4];
    logic signed [47:0] r_prod [4][4];
    logic               r_v1;
    logic signed [vmt_pkg::SumWidth-1:0] s [4];
    logic [vmt_pkg::MagWidth-1:0] r_mag [4];
    logic [3:0]         r_neg;
    logic               r_v2;

    assign v[0] = 32'(signed'(i_item.pos_x[COORD_WIDTH-1:0]));
    assign v[1] = 32'(signed'(i_item.pos_y[COORD_WIDTH-1:0]));
    assign v[2] = 32'(signed'(i_item.pos_z[COORD_WIDTH-1:0]));

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                m[i][j] = i_regs[i*2 + j/2][(j%2)*32 +: 32];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // Products are floored to Q16.16 by dropping the low 16 bits.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int j = 0; j < 4; j++) begin
                for (int i = 0; i < 3; i++) begin
                    r_prod[i][j] <= 48'((64'(v[i]) * 64'(m[i][j])) >>> 16);
                end
                r_prod[3][j] <= 48'(m[3][j]);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            s[j] = 50'(r_prod[0][j]) + 50'(r_prod[1][j])
                 + 50'(r_prod[2][j]) + 50'(r_prod[3][j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int j = 0; j < 4; j++) begin
                r_neg[j] <= s[j][vmt_pkg::SumWidth-1];
                r_mag[j] <= s[j][vmt_pkg::SumWidth-1] ? 49'(-s[j]) : 49'(s[j]);
            end
        end
    end

    assign o_valid = r_v2;
    assign o_mag   = r_mag;
    assign o_neg   = r_neg;

endmodule

// File: rtl/vmt_div.sv
// Pipelined restoring divider: one quotient bit per stage for the three
// numerators in parallel, then saturation and sign.
module vmt_div #(
    parameter int unsigned COORD_WIDTH = vmt_pkg::CoordWidthDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic [vmt_pkg::MagWidth-1:0]  i_mag [4],
    input  logic [3:0]                    i_neg,
    output logic                          o_valid,
    output vmt_pkg::t_out_item            o_item
);

    localparam int unsigned Qw = vmt_pkg::MagWidth + vmt_pkg::FracBits;
    localparam int unsigned Steps = Qw;
    localparam logic [Qw-1:0] Lim = Qw'(1) << (COORD_WIDTH - 1);

    // Remainder is kept one bit wider than the divisor.
    logic [vmt_pkg::MagWidth:0]   r_rem [Steps+1][3];
    logic [Qw-1:0]                r_num [Steps+1][3];
    logic [vmt_pkg::MagWidth-1:0] r_den [Steps+1];
    vmt_pkg::t_div_ctl            r_ctl [Steps+1];

    always_ff @(posedge i_clk) begin
        logic [vmt_pkg::MagWidth:0] sh;
        if (!i_rst_n) begin
            for (int k = 0; k <= Steps; k++) r_ctl[k].valid <= 1'b0;
        end else if (i_adv) begin
            r_ctl[0].valid <= i_valid;
            for (int k = 1; k <= Steps; k++) r_ctl[k].valid <= r_ctl[k-1].valid;
        end
        if (i_adv) begin
            r_den[0] <= i_mag[3];
            r_ctl[0].w_zero <= (i_mag[3] == '0);
            for (int j = 0; j < 3; j++) begin
                r_ctl[0].neg[j] <= i_neg[j] ^ i_neg[3];
                r_rem[0][j] <= '0;
                r_num[0][j] <= {i_mag[j], 16'h0};
            end
            for (int k = 1; k <= Steps; k++) begin
                r_den[k] <= r_den[k-1];
                r_ctl[k].w_zero <= r_ctl[k-1].w_zero;
                r_ctl[k].neg <= r_ctl[k-1].neg;
                for (int j = 0; j < 3; j++) begin
                    sh = {r_rem[k-1][j][vmt_pkg::MagWidth-1:0],
                          r_num[k-1][j][Qw-1]};
                    if (sh >= {1'b0, r_den[k-1]}) begin
                        r_rem[k][j] <= sh - {1'b0, r_den[k-1]};
                        r_num[k][j] <= {r_num[k-1][j][Qw-2:0], 1'b1};
                    end else begin
                        r_rem[k][j] <= sh;
                        r_num[k][j] <= {r_num[k-1][j][Qw-2:0], 1'b0};
                    end
                end
            end
        end
    end

    vmt_pkg::t_out_item n_out;
    vmt_pkg::t_out_item r_out;
    logic               r_ov;
    logic [Qw-1:0]      q;
    logic [Qw-1:0]      qs;
    logic               f;

    always_comb begin
        n_out = '0;
        f = 1'b0;
        for (int j = 0; j < 3; j++) begin
            q = r_num[Steps][j];
            if (r_ctl[Steps].neg[j]) begin
                if (q > Lim) begin
                    f = 1'b1;
                    q = Lim;
                end
                qs = -q;
            end else begin
                if (q > Lim - 1'b1) begin
                    f = 1'b1;
                    q = Lim - 1'b1;
                end
                qs = q;
            end
            n_out[j*32 +: 32] = qs[31:0];
        end
        n_out.range_fault = f;
        if (r_ctl[Steps].w_zero) begin
            n_out = '0;
            n_out.range_fault = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (i_adv) r_ov <= r_ctl[Steps].valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) r_out <= n_out;
    end

    assign o_valid = r_ov;
    assign o_item  = r_out;

endmodule

// File: rtl/vertex_matrix_transform.sv
// Channel   Direction  Handshake          Payload
// in        input      valid / stall      vmt_pkg::t_in_item (pos_x, pos_y, pos_z)
// out       output     valid / stall      vmt_pkg::t_out_item (proj_*, range_fault)
// cfg       input      valid / ready      3-bit register index, 64-bit data
//
// One vertex is taken per cycle while the pipeline is not frozen. The pipeline
// has two multiply-add stages, one divider entry stage, 65 one-bit divider
// stages and the output register. The divider depth sets the latency.
// Reset restores the default matrix and empties the pipeline.
// When the output is stalled and holds a result, the whole pipeline freezes.
module vertex_matrix_transform #(
    parameter int unsigned COORD_WIDTH = vmt_pkg::CoordWidthDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  vmt_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output vmt_pkg::t_out_item o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [vmt_pkg::RegIdxWidth-1:0] i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    logic [63:0] r_regs [vmt_pkg::NumRegs];
    logic        adv;
    logic        mac_v;
    logic [vmt_pkg::MagWidth-1:0] mac_mag [4];
    logic [3:0]  mac_neg;

    // The pipeline moves unless a finished result waits on a stalled output.
    assign adv         = !(o_valid && i_stall);
    assign o_stall     = !adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < vmt_pkg::NumRegs; k++) r_regs[k] <= vmt_pkg::RegReset[k];
        end else if (i_cfg_valid) begin
            r_regs[i_cfg_index] <= i_cfg_data;
        end
    end

    vmt_mac #(.COORD_WIDTH(COORD_WIDTH)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (i_valid),
        .i_item  (i_data),
        .i_regs  (r_regs),
        .o_valid (mac_v),
        .o_mag   (mac_mag),
        .o_neg   (mac_neg)
    );

    vmt_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (mac_v),
        .i_mag   (mac_mag),
        .i_neg   (mac_neg),
        .o_valid (o_valid),
        .o_item  (o_data)
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data))
        else $error("result lost under stall");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without cause");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown(o_data))
        else $error("result carries unknown bits");

endmodule

// File: tb/sv/vmt_checker.sv
`timescale 1ns / 1ps

module vmt_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  vmt_pkg::t_in_item  i_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  vmt_pkg::t_out_item i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results
);

    logic [63:0] matrix_regs [vmt_pkg::NumRegs];
    vmt_pkg::t_out_item projected_q [$];

    // Matrix element M[row][col] as a signed Q16.16 value.
    function automatic longint elem(int row, int col);
        logic [63:0] r;
        r = matrix_regs[row * 2 + col / 2];
        return (col % 2) ? longint'(signed'(r[63:32])) : longint'(signed'(r[31:0]));
    endfunction

    // Quotient in Q16.16, truncated toward zero, saturated to 32 bits.
    function automatic logic [31:0] div_sat(longint num, longint den, ref logic fault);
        logic neg;
        logic [63:0] a, b, q;
        logic [127:0] wide;
        longint lim;
        neg = (num < 0) != (den < 0);
        a = (num < 0) ? -num : num;
        b = (den < 0) ? -den : den;
        lim = 64'sd1 <<< 31;
        if (a / b > 64'(lim >>> vmt_pkg::FracBits)) begin
            fault = 1'b1;
            return neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        // The shifted numerator can exceed 64 bits.
        wide = {64'h0, a} << vmt_pkg::FracBits;
        q = 64'(wide / {64'h0, b});
        if (neg) begin
            if (q > 64'(lim)) begin
                fault = 1'b1;
                q = 64'(lim);
            end
            return 32'(-q);
        end
        if (q > 64'(lim - 1)) begin
            fault = 1'b1;
            q = 64'(lim - 1);
        end
        return 32'(q);
    endfunction

    function automatic vmt_pkg::t_out_item project(vmt_pkg::t_in_item v_in);
        longint vec [4];
        longint sum [4];
        longint prod;
        logic fault;
        vmt_pkg::t_out_item res;
        vec[0] = v_in.pos_x;
        vec[1] = v_in.pos_y;
        vec[2] = v_in.pos_z;
        vec[3] = 64'sd1 <<< vmt_pkg::FracBits;
        fault = 1'b0;
        for (int j = 0; j < 4; j++) begin
            sum[j] = 0;
            for (int i = 0; i < 4; i++) begin
                prod = vec[i] * elem(i, j);
                sum[j] += prod >>> vmt_pkg::FracBits;   // arithmetic shift floors
            end
        end
        if (sum[3] == 0) begin
            res = '0;
            res.range_fault = 1'b1;
            return res;
        end
        res.proj_x = div_sat(sum[0], sum[3], fault);
        res.proj_y = div_sat(sum[1], sum[3], fault);
        res.proj_z = div_sat(sum[2], sum[3], fault);
        res.range_fault = fault;
        return res;
    endfunction

    assign o_pending = projected_q.size();

    always @(posedge i_clk) begin
        vmt_pkg::t_out_item want;
        int mism;
        mism = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < vmt_pkg::NumRegs; i++) matrix_regs[i] = vmt_pkg::RegReset[i];
            projected_q.delete();
            o_errors <= 0;
            o_results <= 0;
        end else begin
            // An item taken at this edge still sees the matrix before the write.
            if (i_valid && !i_stall_in) projected_q.push_back(project(i_data));
            if (i_cfg_valid && i_cfg_ready) matrix_regs[i_cfg_index] = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (projected_q.size() == 0) begin
                    $error("unexpected result %h", i_out_data);
                    mism = 1;
                end else begin
                    want = projected_q.pop_front();
                    if (want.proj_x !== i_out_data.proj_x) begin
                        $error("proj_x exp %h got %h", want.proj_x, i_out_data.proj_x);
                        mism++;
                    end
                    if (want.proj_y !== i_out_data.proj_y) begin
                        $error("proj_y exp %h got %h", want.proj_y, i_out_data.proj_y);
                        mism++;
                    end
                    if (want.proj_z !== i_out_data.proj_z) begin
                        $error("proj_z exp %h got %h", want.proj_z, i_out_data.proj_z);
                        mism++;
                    end
                    if (want.range_fault !== i_out_data.range_fault) begin
                        $error("range_fault exp %b got %b", want.range_fault,
                               i_out_data.range_fault);
                        mism++;
                    end
                end
                o_errors <= o_errors + mism;
            end
        end
    end
endmodule

// File: tb/sv/tb_vertex_matrix_transform.sv
`timescale 1ns / 1ps

module tb_vertex_matrix_transform;

    localparam int Latency = 69;
    localparam int CycleLimit = 400000;
    localparam logic [31:0] One = 32'h0001_0000;

    logic i_clk;
    logic i_rst_n;
    logic in_valid, in_stall_dut, out_valid, out_stall;
    vmt_pkg::t_in_item in_data;
    vmt_pkg::t_out_item out_data;
    logic cfg_valid, cfg_ready;
    logic [2:0] cfg_index;
    logic [63:0] cfg_data;
    int errors, pending, results;
    int cycles;
    // Idling is switched off for the closing stretch of the run.
    bit calm;
    // Set while the long receiver hold-off runs.
    bit hold_off;

    vertex_matrix_transform dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(in_stall_dut), .i_data(in_data),
        .o_valid(out_valid), .i_stall(out_stall), .o_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    vmt_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall_dut), .i_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // The run is cut off here if the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver stall: random bursts, a long hold-off when requested, none at the end.
    initial begin
        int n;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 10);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // One vertex transfer; the sender idles in random bursts before it.
    task automatic send_vertex(input vmt_pkg::t_in_item v);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= v;
        @(posedge i_clk);
        while (in_stall_dut) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Leaves valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Lets every expected result come out before the matrix changes.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (Latency + 5) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            3: return $urandom_range(0, 32'h0100_0000) - 32'h0080_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic vmt_pkg::t_in_item rand_vertex();
        vmt_pkg::t_in_item v;
        v.pos_x = rand_coord();
        v.pos_y = rand_coord();
        v.pos_z = rand_coord();
        return v;
    endfunction

    task automatic load_matrix(input logic [31:0] m [16]);
        for (int r = 0; r < 4; r++) begin
            write_reg(3'(2 * r), {m[4 * r + 1], m[4 * r]});
            write_reg(3'(2 * r + 1), {m[4 * r + 3], m[4 * r + 2]});
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] mat [16];
        vmt_pkg::t_in_item v;
        cycles = 0;
        calm = 0;
        hold_off = 0;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed vertices against the reset matrix, whose w column is zero
        // except for the constant one, plus field extremes.
        send_vertex('{pos_z: 32'h0, pos_y: 32'h0, pos_x: 32'h0});
        send_vertex('{pos_z: 32'h7fff_ffff, pos_y: 32'h7fff_ffff, pos_x: 32'h7fff_ffff});
        send_vertex('{pos_z: 32'h8000_0000, pos_y: 32'h8000_0000, pos_x: 32'h8000_0000});
        send_vertex('{pos_z: 32'hffff_ffff, pos_y: 32'h1, pos_x: One});
        drain();

        // Identity matrix with w taken from z: z of zero gives a zero divisor,
        // small z makes the quotients saturate both ways.
        foreach (mat[i]) mat[i] = 32'h0;
        mat[0] = One; mat[5] = One; mat[10] = One; mat[11] = One;
        load_matrix(mat);
        send_vertex('{pos_z: 32'h0, pos_y: One, pos_x: One});
        send_vertex('{pos_z: 32'h1, pos_y: 32'h7fff_ffff, pos_x: 32'h8000_0000});
        send_vertex('{pos_z: 32'hffff_ffff, pos_y: 32'h7fff_ffff, pos_x: 32'h8000_0000});
        send_vertex('{pos_z: 32'h0002_0000, pos_y: 32'h0003_0000, pos_x: 32'hfffd_0000});
        send_vertex('{pos_z: 32'h8000_0000, pos_y: 32'h8000_0000, pos_x: 32'h7fff_ffff});
        send_vertex('{pos_z: 32'h7fff_ffff, pos_y: 32'h1, pos_x: 32'hffff_ffff});
        drain();

        // Extreme matrices: all ones in every bit, and the most negative value.
        foreach (mat[i]) mat[i] = 32'hffff_ffff;
        load_matrix(mat);
        for (int i = 0; i < 4; i++) send_vertex(rand_vertex());
        drain();
        foreach (mat[i]) mat[i] = 32'h8000_0000;
        load_matrix(mat);
        for (int i = 0; i < 4; i++) send_vertex(rand_vertex());
        drain();

        // Random phases. Most matrices are perspective-like with a sane w column;
        // the rest are fully random.
        for (int phase = 0; phase < 6; phase++) begin
            for (int i = 0; i < 16; i++) begin
                if (phase % 3 == 2) mat[i] = $urandom;
                else mat[i] = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            end
            if (phase % 3 != 2) mat[15] = One;
            load_matrix(mat);
            if (phase == 1) begin
                // The receiver holds off long enough that the pipeline fills
                // and the block has to stall new input transfers.
                hold_off = 1;
                fork
                    begin
                        repeat (200) @(negedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            if (phase == 5) calm = 1;
            for (int i = 0; i < 60; i++) send_vertex(rand_vertex());
            drain();
        end

        $display("Covered %0d vertex results over reset, identity, extreme and random matrices,",
                 results);
        $display("including zero divisors, saturation and a long output hold-off.");
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
